// File: sv/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by every other file of the block but lkvc_ram.
`default_nettype none
package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int KEY_W = 16;
    localparam int VAL_W = 16;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic latch_req;
        logic lookup;
        logic update;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// File: sv/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg, lkvc_ctrl, lkvc_dp (and lkvc_ram below it).
//
//  port group   dir   beat contents (low bits first)
//  s_*          in    tuser: mode; tdata: key[15:0], write_value[31:16]
//  m_*          out   tuser: hit;  tdata: read_value[15:0]
//  cfg_*        in    cfg_wdata: capacity, written when cfg_we is high
//
// Each request passes through the sequencer states in order: accept, parallel
// key/rank match, rank and value RAM update, output register load. A new beat is
// accepted only in the idle state, once the previous request has been handed off.
// Synchronous active-low reset empties the cache and sets capacity to 16.
// A waiting result stalls the next load, and no new beat is accepted meanwhile.
`default_nettype none
module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [2*KEY_W-1:0] s_tdata,   // key, write_value
    input  wire logic               s_tuser,   // mode
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [VAL_W-1:0]   m_tdata,   // read_value
    output logic                    m_tuser,   // hit
    input  wire logic               cfg_we,
    input  wire logic [CAP_W-1:0]   cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted while a request is in flight");

    a_seq_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##1 cmd.lookup ##1 cmd.update)
        else $error("lookup/update sequence broken");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: sv/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lkvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/lkvc_ctrl.sv
// Request sequencer: accept, lookup, update, hand off to the output register.
// Depends on lkvc_pkg.
`default_nettype none
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/lkvc_dp.sv
// Datapath: key match array, recency ranks, value RAM, output register.
// Depends on lkvc_pkg and lkvc_ram.
`default_nettype none
module lkvc_dp
    import lkvc_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic [2*KEY_W-1:0]   s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 cfg_we,
    input  wire logic [CAP_W-1:0]     cfg_wdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [VAL_W-1:0]     m_tdata,
    output logic                      m_tuser
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [CAP_W-1:0]      capacity_reg;
    logic                  req_mode_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_val_reg;

    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [IDX_W-1:0]      rank_reg  [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [OCC_W-1:0]      occ_reg;

    logic                  hit_reg;
    logic                  fill_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [IDX_W-1:0]      hit_rank_reg;
    logic [IDX_W-1:0]      victim_idx_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [VAL_W-1:0]      out_data_reg;

    logic                  hit_next;
    logic [IDX_W-1:0]      hit_idx_next;
    logic [IDX_W-1:0]      hit_rank_next;
    logic [IDX_W-1:0]      victim_idx_next;
    logic [IDX_W-1:0]      lru_rank;
    logic [CMP_W-1:0]      eff_cap;
    logic [IDX_W-1:0]      target;
    logic [OCC_W-1:0]      old_rank;
    logic                  do_write;
    logic                  ram_we;
    logic [VALUE_BITS-1:0] ram_rdata;

    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(capacity_reg);
        end
    end

    // keys are unique among valid entries, so OR-encoding the match is exact
    assign lru_rank = IDX_W'(occ_reg - OCC_W'(1));

    always_comb begin
        hit_next        = 1'b0;
        hit_idx_next    = '0;
        hit_rank_next   = '0;
        victim_idx_next = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (valid_reg[i] && key_reg[i] == req_key_reg) begin
                hit_next      = 1'b1;
                hit_idx_next  = hit_idx_next | IDX_W'(i);
                hit_rank_next = hit_rank_next | rank_reg[i];
            end
            if (valid_reg[i] && rank_reg[i] == lru_rank) begin
                victim_idx_next = victim_idx_next | IDX_W'(i);
            end
        end
    end

    // fill slots are always taken in order, so the free slot is the count
    always_comb begin
        if (hit_reg) begin
            target   = hit_idx_reg;
            old_rank = OCC_W'(hit_rank_reg);
        end else if (fill_reg) begin
            target   = IDX_W'(occ_reg);
            old_rank = occ_reg;
        end else begin
            target   = victim_idx_reg;
            old_rank = occ_reg - OCC_W'(1);
        end
    end

    assign do_write = cmd.update && (hit_reg || req_mode_reg == MODE_PUT);
    assign ram_we   = cmd.update && req_mode_reg == MODE_PUT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_mode_reg <= s_tuser;
            req_key_reg  <= KEY_BITS'(s_tdata[KEY_W-1:0]);
            req_val_reg  <= VALUE_BITS'(s_tdata[2*KEY_W-1:KEY_W]);
        end
        if (cmd.lookup) begin
            hit_reg        <= hit_next;
            hit_idx_reg    <= hit_idx_next;
            hit_rank_reg   <= hit_rank_next;
            victim_idx_reg <= victim_idx_next;
            fill_reg       <= CMP_W'(occ_reg) < eff_cap;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_write) begin
                if (IDX_W'(i) == target) begin
                    rank_reg[i] <= '0;
                    key_reg[i]  <= req_key_reg;
                end else if (valid_reg[i] && OCC_W'(rank_reg[i]) < old_rank) begin
                    rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end else if (do_write && !hit_reg && fill_reg) begin
            valid_reg[target] <= 1'b1;
            occ_reg           <= occ_reg + OCC_W'(1);
        end
    end

    lkvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (target),
        .wdata (req_val_reg),
        .raddr (hit_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_hit_reg  <= hit_reg;
            out_data_reg <= (hit_reg && req_mode_reg == MODE_GET) ? VAL_W'(ram_rdata) : '0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_hit_reg;

endmodule
`default_nettype wire
